// File: src/ilha_pkg.sv
// Package for the implicit list heap allocator.
// Heap geometry, opcodes, CSR indices, status codes and sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package ilha_pkg;
   localparam int unsigned HEAP_BYTES = 65536;
   localparam int unsigned NWORDS = HEAP_BYTES / 4;
   localparam int unsigned AW = $clog2(NWORDS);
   // Offsets are held one bit wider than the heap so the bound itself fits.
   localparam int unsigned OW = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned WALK_LIMIT = HEAP_BYTES / 8 + 2;
   localparam int unsigned WLW = $clog2(WALK_LIMIT + 1);
   localparam int unsigned CW = 17;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;
   localparam logic CSR_CHUNK = 1'b0;
   localparam logic CSR_FIT = 1'b1;
   localparam logic ST_DONE = 1'b0;
   localparam logic ST_OOM = 1'b1;

   typedef logic [OW-1:0] off_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_INIT,
      S_GROW0,
      S_GROW1,
      S_MRG_A,
      S_MRG_B,
      S_MRG_C,
      S_MRG_D,
      S_MRG_E,
      S_MRG_F,
      S_MRG_G,
      S_MRG_H,
      S_MRG_I,
      S_MRG_J,
      S_FREE_A,
      S_FREE_B,
      S_FREE_C,
      S_FREE_D,
      S_SRCH_A,
      S_SRCH_B,
      S_CARVE_A,
      S_CARVE_B,
      S_CARVE_C,
      S_CARVE_D,
      S_CARVE_E,
      S_CARVE_F,
      S_DONE
   } state_type;
endpackage

// File: src/ilha_ram.sv
// Word heap memory for the allocator: one read or write port, registered read.
// Uses ilha_pkg for the address width and depth.
`timescale 1ns / 1ps
module ilha_ram
   import ilha_pkg::*;
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wr_data,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [NWORDS];

   // Write when enabled; the registered read of the old word happens always.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: src/implicit_list_heap_allocator.sv
// Top level of the implicit list heap allocator.
// Uses ilha_pkg and ilha_ram, which holds the heap words.
//
// Request words (req_op, req_req_bytes, req_block_addr) arrive on the req_
// channel; one response word (rsp_status, rsp_payload_addr) per request
// leaves on the rsp_ channel. A request is taken when req_valid is high and
// req_stall low; a response is taken when rsp_valid is high and rsp_stall low.
// Each request is worked on alone by a sequencer around the single heap memory
// port: every tag read issues its address, then uses the registered data.
// A free reads its header, clears both tags and merges with free neighbours.
// An allocate walks the blocks in a fit search, so its time follows the heap
// layout; if no block fits, it grows the break, merges and then carves.
// The first request also writes the prologue and epilogue and
// then grows the heap by the chunk size before it is served.
// The response sits in an output register; while rsp_stall is high it holds
// and no new request is taken until that response is delivered.
// Reset clears the break, rover, list start, the initialised flag and the
// configuration (chunk 4096 bytes, next fit). The heap memory is not cleared.
// Users must write csr_ configuration only while idle; the block never checks.
`timescale 1ns / 1ps
module implicit_list_heap_allocator
   import ilha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_op,
   input  logic [15:0]   req_req_bytes,
   input  logic [15:0]   req_block_addr,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_status,
   output logic [15:0]   rsp_payload_addr,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [CW-1:0] csr_data
);
   state_type state_ff, state_in;
   logic [CW-1:0] chunk_ff;
   logic fit_ff;
   off_type brk_ff, brk_in, rover_ff, rover_in, start_ff, start_in;
   logic init_ff, init_in;

   // Working registers.
   logic op_ff, op_in;
   off_type need_ff, need_in, p_ff, p_in, len_ff, len_in, bef_ff, bef_in;
   off_type sstart_ff, sstart_in, blk_ff, blk_in, glen_ff, glen_in;
   logic bused_ff, bused_in, aused_ff, aused_in;
   logic wrap_ff, wrap_in, pend_ff, pend_in, grown_ff, grown_in;
   logic [WLW-1:0] walk_ff, walk_in;
   logic [2:0] ip_ff, ip_in;
   logic rv_ff, rv_in, rst_ff, rst_in;
   logic [15:0] rpa_ff, rpa_in;

   // Memory port.
   logic mwe;
   logic [31:0] maddr, mwd, mrd;
   logic [AW-1:0] mai;

   function automatic off_type tlen(input logic [31:0] w);
      return off_type'(w[OW-1:0] & ~off_type'(7));
   endfunction

   off_type chunk_len, need_calc;
   logic [CW:0] csum;
   logic [17:0] rsum;
   logic in_rng;
   always_comb begin
      csum = {1'b0, chunk_ff} + (CW+1)'(7);
      chunk_len = off_type'(csum & ~(CW+1)'(7));
      // A rounded chunk beyond the offset width can never be grown either.
      if (csum[CW]) chunk_len = ~off_type'(7);
      if (chunk_len < off_type'(16)) chunk_len = off_type'(16);
      rsum = {2'b0, req_req_bytes} + 18'd15;
      need_calc = (req_req_bytes <= 16'd8) ? off_type'(16)
                : off_type'(rsum & ~18'd7);
   end

   // Out of range word accesses are dropped; reads of them give zero.
   logic rd_oob_ff;
   assign in_rng = (maddr >> 2) < 32'(NWORDS);
   assign mai = maddr[AW+1:2];

   ilha_ram u_ram (
      .clock  (clock),
      .wr_en  (mwe & in_rng),
      .addr   (mai),
      .wr_data(mwd),
      .rd_data(mrd)
   );
   logic [31:0] rdw;
   assign rdw = rd_oob_ff ? 32'd0 : mrd;
   off_type rlen;
   assign rlen = tlen(rdw);

   assign req_stall = (state_ff != S_IDLE) | rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_payload_addr = rpa_ff;

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chunk_ff <= CW'(4096);
         fit_ff <= 1'b1;
         brk_ff <= '0;
         rover_ff <= '0;
         start_ff <= '0;
         init_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         brk_ff <= brk_in;
         rover_ff <= rover_in;
         start_ff <= start_in;
         init_ff <= init_in;
         rv_ff <= rv_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_CHUNK: chunk_ff <= csr_data;
               CSR_FIT:   fit_ff <= csr_data[0];
               default:   ;
            endcase
         end
      end
      rd_oob_ff <= ~in_rng;
      op_ff <= op_in; need_ff <= need_in; p_ff <= p_in; len_ff <= len_in;
      bef_ff <= bef_in; sstart_ff <= sstart_in; blk_ff <= blk_in;
      glen_ff <= glen_in; bused_ff <= bused_in; aused_ff <= aused_in;
      wrap_ff <= wrap_in; pend_ff <= pend_in; grown_ff <= grown_in;
      walk_ff <= walk_in; ip_ff <= ip_in; rst_ff <= rst_in; rpa_ff <= rpa_in;
   end

   // Sequencer. Each read state issues an address; the next state uses rdw.
   // pend_ff marks a phase that has issued its read and waits for data.
   always_comb begin
      state_in = state_ff;
      brk_in = brk_ff; rover_in = rover_ff; start_in = start_ff; init_in = init_ff;
      op_in = op_ff; need_in = need_ff; p_in = p_ff; len_in = len_ff;
      bef_in = bef_ff; sstart_in = sstart_ff; blk_in = blk_ff; glen_in = glen_ff;
      bused_in = bused_ff; aused_in = aused_ff; wrap_in = wrap_ff;
      pend_in = 1'b0; grown_in = grown_ff; walk_in = walk_ff; ip_in = ip_ff;
      rv_in = rv_ff; rst_in = rst_ff; rpa_in = rpa_ff;
      mwe = 1'b0; maddr = '0; mwd = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in = req_op;
               need_in = need_calc;
               p_in = off_type'(req_block_addr);
               rst_in = ST_DONE; rpa_in = '0;
               ip_in = '0;
               state_in = init_ff ? (req_op == OP_FREE ? S_FREE_A : S_SRCH_A) : S_INIT;
            end
         end
         // Prologue and epilogue, one word a cycle, then the first growth.
         S_INIT: begin
            mwe = 1'b1;
            maddr = {27'd0, ip_ff, 2'b00};
            unique case (ip_ff[1:0])
               2'd0: mwd = 32'd0;
               2'd1: mwd = 32'd9;
               2'd2: mwd = 32'd9;
               default: mwd = 32'd1;
            endcase
            ip_in = ip_ff + 3'd1;
            if (ip_ff == 3'd3) begin
               brk_in = off_type'(16); start_in = off_type'(8);
               rover_in = off_type'(8); init_in = 1'b1;
               glen_in = chunk_len; grown_in = 1'b0; ip_in = 3'd4;
               state_in = S_GROW0;
            end
         end
         // Growth: write header, footer, new epilogue; then merge.
         S_GROW0: begin
            if (brk_ff > off_type'(HEAP_BYTES) ||
                glen_ff > off_type'(HEAP_BYTES) - brk_ff) begin
               // Setup growth failure is silent; an allocate reports it.
               if (ip_ff == 3'd4) state_in = op_ff == OP_FREE ? S_FREE_A : S_SRCH_A;
               else begin
                  rst_in = ST_OOM; rpa_in = '0; state_in = S_DONE;
               end
            end else begin
               p_in = brk_ff;
               mwe = 1'b1; maddr = 32'(brk_ff) - 32'd4; mwd = 32'(glen_ff);
               state_in = S_GROW1; walk_in = '0;
            end
         end
         S_GROW1: begin
            mwe = 1'b1;
            if (walk_ff == '0) begin
               maddr = 32'(p_ff) + 32'(glen_ff) - 32'd8; mwd = 32'(glen_ff);
               walk_in = WLW'(1);
            end else begin
               maddr = 32'(p_ff) + 32'(glen_ff) - 32'd4; mwd = 32'd1;
               brk_in = p_ff + glen_ff;
               len_in = glen_ff;
               grown_in = 1'b1;
               state_in = S_MRG_A;
            end
         end
         // Merge: read footer before p, giving the previous block start.
         S_MRG_A: begin
            maddr = 32'(p_ff) - 32'd8; state_in = S_MRG_B;
         end
         S_MRG_B: begin
            bef_in = p_ff - rlen;
            maddr = 32'(p_ff - rlen) - 32'd4; state_in = S_MRG_C;
         end
         S_MRG_C: begin
            maddr = 32'(bef_ff) + 32'(rlen) - 32'd8; state_in = S_MRG_D;
         end
         S_MRG_D: begin
            bused_in = rdw[0];
            maddr = 32'(p_ff) - 32'd4; state_in = S_MRG_E;
         end
         S_MRG_E: begin
            len_in = rlen;
            maddr = 32'(p_ff) + 32'(rlen) - 32'd4; state_in = S_MRG_F;
         end
         S_MRG_F: begin
            aused_in = rdw[0];
            if (!rdw[0]) len_in = len_ff + rlen;
            if (bused_ff && rdw[0]) state_in = S_MRG_J;
            else if (!bused_ff) begin
               maddr = 32'(bef_ff) - 32'd4; state_in = S_MRG_G;
            end else state_in = S_MRG_H;
         end
         S_MRG_G: begin
            len_in = len_ff + rlen; p_in = bef_ff; state_in = S_MRG_H;
         end
         S_MRG_H: begin
            mwe = 1'b1; maddr = 32'(p_ff) - 32'd4; mwd = 32'(len_ff);
            state_in = S_MRG_I;
         end
         S_MRG_I: begin
            mwe = 1'b1; maddr = 32'(p_ff) + 32'(len_ff) - 32'd8; mwd = 32'(len_ff);
            state_in = S_MRG_J;
         end
         // Rover fix-up uses the size now in p's header.
         S_MRG_J: begin
            if (!pend_ff) begin
               maddr = 32'(p_ff) - 32'd4; pend_in = 1'b1;
            end else begin
               if (rover_ff > p_ff && rover_ff < p_ff + rlen) rover_in = p_ff;
               if (ip_ff == 3'd4) begin
                  state_in = op_ff == OP_FREE ? S_FREE_A : S_SRCH_A;
               end else if (ip_ff == 3'd5) begin
                  blk_in = p_ff; state_in = S_CARVE_A;
               end else begin
                  rst_in = ST_DONE; rpa_in = '0; state_in = S_DONE;
               end
            end
         end
         // Free: read own header, rewrite tags cleared, then merge.
         S_FREE_A: begin
            maddr = 32'(p_ff) - 32'd4; ip_in = 3'd6; state_in = S_FREE_B;
         end
         S_FREE_B: begin
            len_in = rlen;
            mwe = 1'b1; maddr = 32'(p_ff) - 32'd4; mwd = 32'(rlen);
            state_in = S_FREE_C;
         end
         S_FREE_C: begin
            mwe = 1'b1; maddr = 32'(p_ff) + 32'(len_ff) - 32'd8; mwd = 32'(len_ff);
            state_in = S_MRG_A;
         end
         S_FREE_D: state_in = S_MRG_A;
         // Search setup.
         S_SRCH_A: begin
            walk_in = '0; wrap_in = 1'b0; ip_in = 3'd5;
            sstart_in = rover_ff;
            p_in = fit_ff ? rover_ff : start_ff;
            maddr = 32'(fit_ff ? rover_ff : start_ff) - 32'd4;
            state_in = S_SRCH_B;
         end
         // Per block: issue the header read, then examine it.
         S_SRCH_B: begin
            if (pend_ff || walk_ff == WLW'(WALK_LIMIT) ||
                (wrap_ff && p_ff >= sstart_ff)) begin
               // Examine phase (pend_ff) or walk end.
               if (!pend_ff) begin
                  if (fit_ff && !wrap_ff) begin
                     wrap_in = 1'b1; walk_in = '0; p_in = start_ff;
                     rover_in = start_ff;
                  end else begin
                     glen_in = (need_ff > chunk_len) ? need_ff : chunk_len;
                     state_in = S_GROW0;
                  end
               end else if (rlen == '0) begin
                  if (fit_ff && !wrap_ff) begin
                     wrap_in = 1'b1; walk_in = '0; p_in = start_ff;
                     rover_in = start_ff;
                  end else begin
                     glen_in = (need_ff > chunk_len) ? need_ff : chunk_len;
                     state_in = S_GROW0;
                  end
               end else if (rlen >= need_ff && !rdw[0]) begin
                  blk_in = p_ff; state_in = S_CARVE_A;
               end else begin
                  p_in = p_ff + rlen; walk_in = walk_ff + WLW'(1);
                  if (fit_ff) rover_in = p_ff + rlen;
               end
            end else begin
               maddr = 32'(p_ff) - 32'd4; pend_in = 1'b1;
            end
         end
         // Carve: read size, write tags, split remainder.
         S_CARVE_A: begin
            maddr = 32'(blk_ff) - 32'd4; state_in = S_CARVE_B;
         end
         S_CARVE_B: begin
            len_in = rlen;
            if (rlen >= need_ff && rlen - need_ff >= off_type'(16)) begin
               glen_in = need_ff;
            end else glen_in = rlen;
            state_in = S_CARVE_C;
         end
         S_CARVE_C: begin
            mwe = 1'b1; maddr = 32'(blk_ff) - 32'd4; mwd = 32'(glen_ff) | 32'd1;
            state_in = S_CARVE_D;
         end
         S_CARVE_D: begin
            mwe = 1'b1; maddr = 32'(blk_ff) + 32'(glen_ff) - 32'd8;
            mwd = 32'(glen_ff) | 32'd1;
            state_in = (glen_ff != len_ff) ? S_CARVE_E : S_DONE;
            rst_in = ST_DONE; rpa_in = blk_ff[15:0];
         end
         S_CARVE_E: begin
            mwe = 1'b1; maddr = 32'(blk_ff) + 32'(glen_ff) - 32'd4;
            mwd = 32'(len_ff - glen_ff);
            state_in = S_CARVE_F;
         end
         S_CARVE_F: begin
            mwe = 1'b1; maddr = 32'(blk_ff) + 32'(len_ff) - 32'd8;
            mwd = 32'(len_ff - glen_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// File: src/ilha_checker.sv
// Port-level checker for the heap allocator, bound to the top level.
// Uses ilha_pkg for the status codes.
`timescale 1ns / 1ps
module ilha_checker
   import ilha_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic [15:0] rsp_payload_addr
);
   // A failed allocate reports payload zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OOM |-> rsp_payload_addr == 16'd0)
      else $error("out of memory word with nonzero payload");
   // A successful payload offset is word aligned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_addr[1:0] == 2'b00)
      else $error("misaligned payload");
   // While a response waits, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with response pending");
   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_addr))
      else $error("stalled response changed");
endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_payload_addr(rsp_payload_addr)
);

// File: dv/implicit_list_heap_allocator_tb.sv
// Self-checking testbench for the implicit list heap allocator.
// Depends on ilha_pkg and the implicit_list_heap_allocator RTL.
// Drives directed and random allocate/free words and checks every response
// against a boundary-tag shadow heap or a typed directed answer.
`timescale 1ns / 1ps
module implicit_list_heap_allocator_tb;
   import ilha_pkg::*;

   localparam int unsigned MIN_BLK = 16;
   localparam int unsigned CYCLE_LIMIT = 6000000;
   localparam int unsigned PHASE_ITEMS = 375;
   localparam int unsigned MAX_LIVE = 64;

   typedef struct packed {
      logic        status;
      logic [15:0] addr;
   } answer_type;

   typedef enum logic [2:0] {K_ALLOC, K_FREE, K_CHUNK, K_FIT} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int unsigned  value;  // bytes, chunk, fit mode, or alloc slot to free
      bit           typed;
      answer_type   answer;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_op = OP_ALLOC;
   logic [15:0]   req_req_bytes = '0;
   logic [15:0]   req_block_addr = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_status;
   logic [15:0]   rsp_payload_addr;
   logic          csr_write = 1'b0;
   logic          csr_index = CSR_CHUNK;
   logic [CW-1:0] csr_data = '0;

   implicit_list_heap_allocator dut (.*);

   always #2 clock = ~clock;

   // Shadow heap and allocator state.
   logic [31:0] shadow_heap [NWORDS];
   int unsigned brk_off, rover, first_blk, chunk_cfg, fit_cfg;
   bit          heap_ready;

   answer_type  pending_answers[$];
   int unsigned live_blocks[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          quiet = 1'b0;
   bit          calm = 1'b0;
   int unsigned stall_left = 0;

   function automatic logic [31:0] heap_rd(int unsigned a);
      int unsigned i = a >> 2;
      return (i < NWORDS) ? shadow_heap[i] : 32'd0;
   endfunction

   function automatic void heap_wr(int unsigned a, logic [31:0] v);
      int unsigned i = a >> 2;
      if (i < NWORDS) shadow_heap[i] = v;
   endfunction

   function automatic int unsigned tag_len(int unsigned a);
      return heap_rd(a) & ~32'h7;
   endfunction

   function automatic bit tag_used(int unsigned a);
      return heap_rd(a) & 32'h1;
   endfunction

   function automatic void put_tags(int unsigned p, int unsigned len, bit used);
      heap_wr(p - 4, len | used);
      heap_wr(p + len - 8, len | used);
   endfunction

   // Merge a free block with whichever neighbors are free.
   function automatic int unsigned coalesce(int unsigned p);
      int unsigned prev_p, len;
      bit prev_used, next_used;
      prev_p = p - tag_len(p - 8);
      prev_used = tag_used(prev_p + tag_len(prev_p - 4) - 8);
      len = tag_len(p - 4);
      next_used = tag_used(p + len - 4);
      if (!prev_used && next_used) begin
         p = prev_p;
         len += tag_len(p - 4);
         put_tags(p, len, 1'b0);
      end else if (prev_used && !next_used) begin
         len += tag_len(p + len - 4);
         put_tags(p, len, 1'b0);
      end else if (!prev_used && !next_used) begin
         len += tag_len(p + len - 4);
         p = prev_p;
         len += tag_len(p - 4);
         put_tags(p, len, 1'b0);
      end
      if (rover > p && rover < p + tag_len(p - 4)) rover = p;
      return p;
   endfunction

   function automatic bit extend_break(int unsigned len, output int unsigned blk);
      int unsigned p;
      blk = 0;
      if (brk_off > HEAP_BYTES || len > HEAP_BYTES - brk_off) return 1'b0;
      p = brk_off;
      brk_off += len;
      put_tags(p, len, 1'b0);
      heap_wr(p + len - 4, 32'd1);
      blk = coalesce(p);
      return 1'b1;
   endfunction

   function automatic int unsigned growth_len();
      int unsigned g = (chunk_cfg + 7) & ~32'h7;
      return (g < MIN_BLK) ? MIN_BLK : g;
   endfunction

   // Prologue, epilogue and the first growth, done on the first request.
   function automatic void build_heap();
      int unsigned unused;
      brk_off = 16;
      heap_wr(0, 32'd0);
      heap_wr(4, 32'd9);
      heap_wr(8, 32'd9);
      heap_wr(12, 32'd1);
      first_blk = 8;
      rover = 8;
      heap_ready = 1'b1;
      void'(extend_break(growth_len(), unused));
   endfunction

   // Walk blocks from p, stopping at a fit, a zero size or the walk limit.
   // When bounded, the walk also stops once p reaches stop_at.
   function automatic bit walk_fit(inout int unsigned p, input int unsigned need,
                                   input bit bounded, input int unsigned stop_at);
      int unsigned s;
      for (int unsigned n = 0; n < WALK_LIMIT; n++) begin
         if (bounded && p >= stop_at) return 1'b0;
         s = tag_len(p - 4);
         if (s == 0) return 1'b0;
         if (s >= need && !tag_used(p - 4)) return 1'b1;
         p += s;
      end
      return 1'b0;
   endfunction

   function automatic bit locate_block(int unsigned need, output int unsigned blk);
      int unsigned start, p;
      blk = 0;
      if (fit_cfg) begin
         start = rover;
         if (walk_fit(rover, need, 1'b0, 0)) begin
            blk = rover;
            return 1'b1;
         end
         rover = first_blk;
         if (walk_fit(rover, need, 1'b1, start)) begin
            blk = rover;
            return 1'b1;
         end
         return 1'b0;
      end
      p = first_blk;
      if (walk_fit(p, need, 1'b0, 0)) begin
         blk = p;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void place(int unsigned p, int unsigned need);
      int unsigned have = tag_len(p - 4);
      if (have >= need && have - need >= MIN_BLK) begin
         put_tags(p, need, 1'b1);
         put_tags(p + need, have - need, 1'b0);
      end else begin
         put_tags(p, have, 1'b1);
      end
   endfunction

   // Update the shadow heap for one request word and return its response.
   function automatic answer_type serve_request(logic op, int unsigned nbytes,
                                                int unsigned addr);
      answer_type ans;
      int unsigned need, blk, glen;
      ans = '0;
      if (!heap_ready) build_heap();
      if (op == OP_FREE) begin
         put_tags(addr, tag_len(addr - 4), 1'b0);
         void'(coalesce(addr));
         return ans;
      end
      need = (nbytes <= 8) ? MIN_BLK : 8 * ((nbytes + 15) / 8);
      if (locate_block(need, blk)) begin
         place(blk, need);
         ans.addr = blk[15:0];
         return ans;
      end
      glen = growth_len();
      if (need > glen) glen = need;
      if (extend_break(glen, blk)) begin
         place(blk, need);
         ans.addr = blk[15:0];
      end else begin
         ans.status = ST_OOM;
      end
      return ans;
   endfunction

   // Present one request word, hold it until taken, then record its response.
   task automatic issue(logic op, int unsigned nbytes, int unsigned addr,
                        bit typed, answer_type typed_ans, output answer_type got);
      req_valid <= 1'b1;
      req_op <= op;
      req_req_bytes <= (op == OP_ALLOC) ? nbytes[15:0] : 16'($urandom);
      req_block_addr <= (op == OP_FREE) ? addr[15:0] : 16'($urandom);
      do @(posedge clock); while (req_stall);
      got = serve_request(op, nbytes, addr);
      pending_answers.push_back(typed ? typed_ans : got);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Let every response arrive, then give the block time to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int unsigned value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CW-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_CHUNK) chunk_cfg = value & 32'h1FFFF;
      else fit_cfg = value & 1;
   endtask

   function automatic int unsigned random_size();
      int unsigned r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 64);
      if (r < 90) return $urandom_range(65, 1024);
      if (r < 98) return $urandom_range(1025, 8192);
      return $urandom_range(0, 65535);
   endfunction

   // Directed rows: the typed answers follow from an empty heap and tiny growth.
   stim_row_type directed_rows[] = '{
      '{K_CHUNK, 65536, 1'b0, '0},
      '{K_FIT, 0, 1'b0, '0},
      '{K_ALLOC, 0, 1'b1, '{ST_OOM, 16'd0}},
      '{K_CHUNK, 16, 1'b0, '0},
      '{K_ALLOC, 0, 1'b1, '{ST_DONE, 16'd16}},
      '{K_ALLOC, 8, 1'b0, '0},
      '{K_ALLOC, 9, 1'b0, '0},
      '{K_ALLOC, 65535, 1'b1, '{ST_OOM, 16'd0}},
      '{K_ALLOC, 100, 1'b0, '0},
      '{K_FREE, 2, 1'b0, '0},
      '{K_FREE, 1, 1'b0, '0},
      '{K_ALLOC, 1, 1'b0, '0},
      '{K_FIT, 1, 1'b0, '0},
      '{K_CHUNK, 17, 1'b0, '0},
      '{K_ALLOC, 24, 1'b0, '0},
      '{K_ALLOC, 200, 1'b0, '0},
      '{K_FREE, 3, 1'b0, '0},
      '{K_ALLOC, 0, 1'b0, '0},
      '{K_CHUNK, 5, 1'b0, '0},
      '{K_ALLOC, 3000, 1'b0, '0},
      '{K_FREE, 8, 1'b0, '0},
      '{K_FREE, 10, 1'b0, '0},
      '{K_ALLOC, 65535, 1'b1, '{ST_OOM, 16'd0}}
   };

   // Response checker.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: status %0d addr %0d",
                        rsp_status, rsp_payload_addr);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_payload_addr !== want.addr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Response mismatch: expected status %0d addr %0d, got %0d %0d",
                           want.status, want.addr, rsp_status, rsp_payload_addr);
            end
         end
      end
   end

   // Receiver stalls in bursts, with calm stretches and none near the end.
   always @(posedge clock) begin
      if ($urandom_range(0, 127) == 0) calm = ~calm;
      if (reset || quiet || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      answer_type got;
      int unsigned slot_addr[$];
      int unsigned pick, waited;
      chunk_cfg = 4096;
      fit_cfg = 1;
      heap_ready = 1'b0;
      brk_off = 0;
      rover = 0;
      first_blk = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: frees name the alloc slot whose block they release.
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            K_CHUNK: write_reg(CSR_CHUNK, directed_rows[i].value);
            K_FIT: write_reg(CSR_FIT, directed_rows[i].value);
            K_FREE: begin
               pick = slot_addr[directed_rows[i].value];
               issue(OP_FREE, 0, pick, 1'b0, '0, got);
               slot_addr[directed_rows[i].value] = 0;
            end
            default: begin
               issue(OP_ALLOC, directed_rows[i].value, 0, directed_rows[i].typed,
                     directed_rows[i].answer, got);
               slot_addr.push_back((got.status == ST_DONE) ? got.addr : 0);
            end
         endcase
      end
      foreach (slot_addr[i])
         if (slot_addr[i] != 0) live_blocks.push_back(slot_addr[i]);

      // Random phases, each under a new configuration written while idle.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_CHUNK, 4096);
               write_reg(CSR_FIT, 1);
            end
            1: begin
               write_reg(CSR_CHUNK, 65536);
               write_reg(CSR_FIT, 0);
            end
            2: begin
               write_reg(CSR_CHUNK, $urandom_range(0, 131071));
               write_reg(CSR_FIT, $urandom_range(0, 1));
            end
            default: begin
               write_reg(CSR_CHUNK, 16);
               write_reg(CSR_FIT, 1);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n >= PHASE_ITEMS - 250) quiet = 1'b1;
            if (live_blocks.size() != 0 &&
                (live_blocks.size() >= MAX_LIVE || $urandom_range(0, 99) < 45)) begin
               pick = $urandom_range(0, live_blocks.size() - 1);
               issue(OP_FREE, 0, live_blocks[pick], 1'b0, '0, got);
               live_blocks.delete(pick);
            end else begin
               issue(OP_ALLOC, random_size(), 0, 1'b0, '0, got);
               if (got.status == ST_DONE) live_blocks.push_back(got.addr);
            end
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending_answers.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
